// File: rtl/core/subset_rank_bound_saturation_top_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef SUBSET_RANK_BOUND_SATURATION_TOP_ASSERT_SVH
`define SUBSET_RANK_BOUND_SATURATION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRBS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRBS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/srbs_pkg.sv
`default_nettype none

package srbs_pkg;

  // Fixed field widths of the item and result ports
  localparam int unsigned SubsetW  = 5;
  localparam int unsigned RankW    = 8;
  localparam int unsigned FiredW   = 13;
  localparam int unsigned PointW   = 3;

  localparam logic [PointW-1:0] PointRst = 3'd5;

  // Defaults for the top-level parameters
  localparam int unsigned MaxPointsDef = 5;
  localparam int unsigned RankBitsDef  = 8;

  // Operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpRun  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [SubsetW-1:0] subset_index;
    logic [RankW-1:0]   rank_upper;
    logic [RankW-1:0]   rank_lower;
  } item_t;

  typedef struct packed {
    logic [SubsetW-1:0] subset_id;
    logic [RankW-1:0]   upper_bound;
    logic [RankW-1:0]   lower_bound;
    logic [FiredW-1:0]  fired_count;
    logic               last;
  } result_t;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StEmit
  } state_e;

  // Micro-steps of one pair, in execution order
  typedef enum logic [3:0] {
    StRs1,
    StRs3,
    StRs2,
    StRs4,
    StSumU5,
    StRs5,
    StSumU6,
    StRs6,
    StSumL7,
    StRs7,
    StSumL8,
    StRs8
  } step_e;

endpackage

`default_nettype wire

// File: rtl/core/srbs_ram.sv
`default_nettype none

module srbs_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  output logic      [Width-1:0] rdata_a_o,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// File: rtl/core/subset_rank_bound_saturation_top.sv
// Load item: one per cycle while idle, written at the edge that accepts it, no result.
// Run item: each ordered pair takes 12 read/update steps, each an issue and an update phase, on
// the two-read-port bound RAMs; busy stays high from the accepting edge until the last strobe.
// The run ends in 2^n consecutive result strobes; the
// last shows with busy low, so the next item can be taken at its edge. No receiver stall.
// Reset sets point_count to 5; every bound reads as its power-on value via per-entry flags.
`default_nettype none

module subset_rank_bound_saturation_top import srbs_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef,
  parameter int unsigned RankBits  = RankBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire item_t             item_i,
  output logic                   result_valid_o,
  output result_t                result_o,
  input  wire logic              cfg_we_i,
  input  wire logic [PointW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW  = MaxPoints;
  localparam int unsigned Depth = 1 << MaxPoints;
  localparam int unsigned SumW  = RankBits + 1;
  localparam int unsigned ValW  = RankBits + 2;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [RankBits-1:0] rank_t;

  state_e             state_q, state_d;
  step_e              step_q, step_d;
  logic               phase_q, phase_d;
  idx_t               x_q, x_d, y_q, y_d, top_q, top_d, k_q, k_d;
  logic [FiredW-1:0]  fired_q, fired_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [PointW-1:0]  point_q;
  logic [Depth-1:0]   valid_u_q, valid_l_q;
  logic               emit_v_q, emit_v_d, emit_last_q, emit_last_d;
  idx_t               emit_k_q;

  idx_t  ua_addr, ub_addr, la_addr, lb_addr;
  idx_t  ua_addr_q, ub_addr_q, la_addr_q, lb_addr_q;
  logic  ua_vld_q, ub_vld_q, la_vld_q, lb_vld_q;
  rank_t ua_ram, ub_ram, la_ram, lb_ram;
  rank_t ua, ub, la, lb;

  logic  u_we, l_we, fire;
  idx_t  u_waddr, l_waddr;
  rank_t u_wdata, l_wdata;

  logic              accept, load_fits, sub_xy, sub_yx, lt_56, gt_78;
  idx_t              mi, mu, top_run;
  logic [PointW-1:0] n_eff;
  logic [ValW-1:0]   v_56, v_78;

  function automatic rank_t upper_rst(idx_t a);
    int unsigned c;
    c = $countones(a);
    if (c > 4) begin
      c = 4;
    end
    return RankBits'(c);
  endfunction

  function automatic rank_t lower_rst(idx_t a);
    return RankBits'(a != '0);
  endfunction

  assign busy      = (state_q != StIdle);
  assign accept    = start && !busy;
  assign load_fits = ((32'(item_i.subset_index) >> MaxPoints) == 32'd0);

  assign mi     = x_q & y_q;
  assign mu     = x_q | y_q;
  assign sub_xy = (mi == x_q);
  assign sub_yx = (mi == y_q);

  always_comb begin
    n_eff = point_q;
    if (point_q == '0) begin
      n_eff = PointW'(1);
    end else if (point_q > PointW'(MaxPoints)) begin
      n_eff = PointW'(MaxPoints);
    end
  end
  assign top_run = IdxW'((32'd1 << n_eff) - 32'd1);

  // Bound RAMs: the read data of an entry never written is replaced by its reset value
  srbs_ram #(.Width(RankBits), .Depth(Depth)) u_upper_ram (
    .clk_i     (clk_i),
    .we_i      (u_we),
    .waddr_i   (u_waddr),
    .wdata_i   (u_wdata),
    .raddr_a_i (ua_addr),
    .rdata_a_o (ua_ram),
    .raddr_b_i (ub_addr),
    .rdata_b_o (ub_ram)
  );

  srbs_ram #(.Width(RankBits), .Depth(Depth)) u_lower_ram (
    .clk_i     (clk_i),
    .we_i      (l_we),
    .waddr_i   (l_waddr),
    .wdata_i   (l_wdata),
    .raddr_a_i (la_addr),
    .rdata_a_o (la_ram),
    .raddr_b_i (lb_addr),
    .rdata_b_o (lb_ram)
  );

  assign ua = ua_vld_q ? ua_ram : upper_rst(ua_addr_q);
  assign ub = ub_vld_q ? ub_ram : upper_rst(ub_addr_q);
  assign la = la_vld_q ? la_ram : lower_rst(la_addr_q);
  assign lb = lb_vld_q ? lb_ram : lower_rst(lb_addr_q);

  // Submodularity candidates
  assign v_56  = {1'b0, sum_q} - {2'b00, la};
  assign v_78  = {1'b0, sum_q} - {2'b00, ua};
  assign lt_56 = $signed(v_56) < $signed({2'b00, ua});
  assign gt_78 = $signed(v_78) > $signed({2'b00, la});

  // Read addresses for the issue cycle of each step, and for the reads while emitting
  always_comb begin
    ua_addr = x_q;
    ub_addr = y_q;
    la_addr = x_q;
    lb_addr = y_q;
    if (state_q == StEmit) begin
      ua_addr = k_q;
      la_addr = k_q;
    end else begin
      unique case (step_q) inside
        StRs1, StRs2, StRs3, StRs4, StSumU5, StSumU6: begin
        end
        StRs5: begin
          la_addr = mi;
          ua_addr = mu;
        end
        StRs6: begin
          la_addr = mu;
          ua_addr = mi;
        end
        StSumL7, StSumL8: begin
          la_addr = mi;
          lb_addr = mu;
        end
        StRs7: begin
          ua_addr = y_q;
          la_addr = x_q;
        end
        StRs8: begin
          ua_addr = x_q;
          la_addr = y_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    phase_d     = phase_q;
    x_d         = x_q;
    y_d         = y_q;
    top_d       = top_q;
    k_d         = k_q;
    fired_d     = fired_q;
    sum_d       = sum_q;
    emit_v_d    = 1'b0;
    emit_last_d = 1'b0;
    fire        = 1'b0;
    u_we        = 1'b0;
    u_waddr     = x_q;
    u_wdata     = ua;
    l_we        = 1'b0;
    l_waddr     = x_q;
    l_wdata     = la;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (item_i.operation == OpRun) begin
            state_d = StRun;
            step_d  = StRs1;
            phase_d = 1'b0;
            x_d     = IdxW'(1);
            y_d     = IdxW'(1);
            top_d   = top_run;
            fired_d = '0;
          end else if (load_fits) begin
            u_we    = 1'b1;
            u_waddr = IdxW'(item_i.subset_index);
            u_wdata = RankBits'(item_i.rank_upper);
            l_we    = 1'b1;
            l_waddr = IdxW'(item_i.subset_index);
            l_wdata = RankBits'(item_i.rank_lower);
          end
        end
      end

      StRun: begin
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          unique case (step_q) inside
            StRs1: begin
              fire    = sub_xy && (la > lb);
              l_we    = fire;
              l_waddr = y_q;
              l_wdata = la;
            end
            StRs3: begin
              fire    = sub_xy && (ub < ua);
              u_we    = fire;
              u_waddr = x_q;
              u_wdata = ub;
            end
            StRs2: begin
              fire    = sub_yx && (lb > la);
              l_we    = fire;
              l_waddr = x_q;
              l_wdata = lb;
            end
            StRs4: begin
              fire    = sub_yx && (ub > ua);
              u_we    = fire;
              u_waddr = y_q;
              u_wdata = ua;
            end
            StSumU5, StSumU6: begin
              sum_d = {1'b0, ua} + {1'b0, ub};
            end
            StRs5: begin
              fire    = lt_56;
              u_we    = fire;
              u_waddr = mu;
              u_wdata = v_56[RankBits-1:0];
            end
            StRs6: begin
              fire    = lt_56;
              u_we    = fire;
              u_waddr = mi;
              u_wdata = v_56[RankBits-1:0];
            end
            StSumL7, StSumL8: begin
              sum_d = {1'b0, la} + {1'b0, lb};
            end
            StRs7: begin
              fire    = gt_78;
              l_we    = fire;
              l_waddr = x_q;
              l_wdata = v_78[RankBits-1:0];
            end
            StRs8: begin
              fire    = gt_78;
              l_we    = fire;
              l_waddr = y_q;
              l_wdata = v_78[RankBits-1:0];
            end
            default: begin
            end
          endcase

          if (fire) begin
            fired_d = fired_q + FiredW'(1);
          end

          // Advance to the next step, or to the next pair after the last rule, or to emission after the last pair
          if (step_q == StRs8) begin
            step_d = StRs1;
            if (y_q == top_q) begin
              y_d = IdxW'(1);
              if (x_q == top_q) begin
                state_d = StEmit;
                k_d     = '0;
              end else begin
                x_d = x_q + IdxW'(1);
              end
            end else begin
              y_d = y_q + IdxW'(1);
            end
          end else begin
            step_d = step_e'(step_q + 4'd1);
          end
        end
      end

      StEmit: begin
        emit_v_d    = 1'b1;
        emit_last_d = (k_q == top_q);
        if (k_q == top_q) begin
          state_d = StIdle;
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= StRs1;
      phase_q     <= 1'b0;
      point_q     <= PointRst;
      valid_u_q   <= '0;
      valid_l_q   <= '0;
      emit_v_q    <= 1'b0;
      emit_last_q <= 1'b0;
      fired_q     <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      emit_v_q    <= emit_v_d;
      emit_last_q <= emit_last_d;
      fired_q     <= fired_d;
      if (cfg_we_i) begin
        point_q <= cfg_wdata_i;
      end
      if (u_we) begin
        valid_u_q[u_waddr] <= 1'b1;
      end
      if (l_we) begin
        valid_l_q[l_waddr] <= 1'b1;
      end
    end
  end

  // Payload and read-side tracking registers
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    top_q     <= top_d;
    k_q       <= k_d;
    sum_q     <= sum_d;
    emit_k_q  <= k_q;
    ua_addr_q <= ua_addr;
    ub_addr_q <= ub_addr;
    la_addr_q <= la_addr;
    lb_addr_q <= lb_addr;
    ua_vld_q  <= valid_u_q[ua_addr];
    ub_vld_q  <= valid_u_q[ub_addr];
    la_vld_q  <= valid_l_q[la_addr];
    lb_vld_q  <= valid_l_q[lb_addr];
  end

  assign result_valid_o       = emit_v_q;
  assign result_o.subset_id   = SubsetW'(emit_k_q);
  assign result_o.upper_bound = RankW'(ua);
  assign result_o.lower_bound = RankW'(la);
  assign result_o.fired_count = fired_q;
  assign result_o.last        = emit_last_q;

endmodule

`default_nettype wire

// File: rtl/core/srbs_checker.sv
`default_nettype none

`include "subset_rank_bound_saturation_top_assert.svh"

module srbs_checker import srbs_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    start,
  input wire logic    busy,
  input wire item_t   item_i,
  input wire logic    result_valid_o,
  input wire result_t result_o
);

  // A run item takes the block busy right away
  `SRBS_ASSERT_NXT(a_run_goes_busy, start && !busy && item_i.operation == OpRun, busy, "run item did not raise busy")

  // A load item leaves the block free for the next item
  `SRBS_ASSERT_NXT(a_load_stays_free, start && !busy && item_i.operation == OpLoad, !busy && !result_valid_o, "load item blocked the block or made a result")

  // The final result closes the run
  `SRBS_ASSERT_NXT(a_last_ends_run, result_valid_o && result_o.last, !result_valid_o, "result strobe after last")

  // Results of a run come back to back with ascending subset ids
  `SRBS_ASSERT_NXT(a_emit_in_order, result_valid_o && !result_o.last, result_valid_o && result_o.subset_id == SubsetW'($past(result_o.subset_id) + SubsetW'(1)), "results out of order or gapped")

  // A result is never shown while a new item could be taken mid-run
  `SRBS_ASSERT_IMP(a_result_not_loose, result_valid_o && !result_o.last, busy, "non-final result while idle")

endmodule

bind subset_rank_bound_saturation_top srbs_checker u_srbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srbs_pkg::*;

  localparam int ItemsTotal   = 410;
  localparam int IdleLimit    = 100000;
  localparam int SettleCycles = 4;
  localparam int DrainCycles  = 50;
  localparam int TableDepth   = 32;

  // Predicts the bound tables and the report stream of each saturation pass.
  class bound_scoreboard;
    logic [RankW-1:0]  upper_tab[TableDepth];
    logic [RankW-1:0]  lower_tab[TableDepth];
    logic [PointW-1:0] point_reg;
    result_t           bound_reports_q[$];
    int                mismatches;

    function new();
      int pc;
      for (int i = 0; i < TableDepth; i++) begin
        pc = $countones(i);
        upper_tab[i] = RankW'((pc > 4) ? 4 : pc);
        lower_tab[i] = RankW'((i == 0) ? 0 : 1);
      end
      point_reg  = PointRst;
      mismatches = 0;
    endfunction

    function void set_points(logic [PointW-1:0] value);
      point_reg = value;
    endfunction

    function int pending();
      return bound_reports_q.size();
    endfunction

    // One pass over all ordered pairs; returns how many rules fired.
    function int unsigned saturate_bounds(int unsigned top);
      int unsigned fired;
      int unsigned mi;
      int unsigned mu;
      int          v;
      fired = 0;
      for (int unsigned x = 1; x <= top; x++) begin
        for (int unsigned y = 1; y <= top; y++) begin
          mi = x & y;
          mu = x | y;
          if (mi == x && lower_tab[x] > lower_tab[y]) begin
            lower_tab[y] = lower_tab[x];
            fired++;
          end
          if (mi == x && upper_tab[y] < upper_tab[x]) begin
            upper_tab[x] = upper_tab[y];
            fired++;
          end
          if (mi == y && lower_tab[y] > lower_tab[x]) begin
            lower_tab[x] = lower_tab[y];
            fired++;
          end
          if (mi == y && upper_tab[y] > upper_tab[x]) begin
            upper_tab[y] = upper_tab[x];
            fired++;
          end
          v = int'(upper_tab[x]) + int'(upper_tab[y]) - int'(lower_tab[mi]);
          if (v < int'(upper_tab[mu])) begin
            upper_tab[mu] = v[RankW-1:0];
            fired++;
          end
          v = int'(upper_tab[x]) + int'(upper_tab[y]) - int'(lower_tab[mu]);
          if (v < int'(upper_tab[mi])) begin
            upper_tab[mi] = v[RankW-1:0];
            fired++;
          end
          v = int'(lower_tab[mi]) + int'(lower_tab[mu]) - int'(upper_tab[y]);
          if (v > int'(lower_tab[x])) begin
            lower_tab[x] = v[RankW-1:0];
            fired++;
          end
          v = int'(lower_tab[mi]) + int'(lower_tab[mu]) - int'(upper_tab[x]);
          if (v > int'(lower_tab[y])) begin
            lower_tab[y] = v[RankW-1:0];
            fired++;
          end
        end
      end
      return fired;
    endfunction

    function void note_item(item_t it);
      int unsigned n;
      int unsigned count;
      int unsigned fired;
      result_t     r;
      if (it.operation == OpLoad) begin
        upper_tab[it.subset_index] = it.rank_upper;
        lower_tab[it.subset_index] = it.rank_lower;
        return;
      end
      // clamp the point count into 1..MaxPoints
      n = 32'(point_reg);
      if (n < 1) n = 1;
      if (n > MaxPointsDef) n = MaxPointsDef;
      count = 1 << n;
      fired = saturate_bounds(count - 1);
      for (int unsigned k = 0; k < count; k++) begin
        r.subset_id   = k[SubsetW-1:0];
        r.upper_bound = upper_tab[k];
        r.lower_bound = lower_tab[k];
        r.fired_count = fired[FiredW-1:0];
        r.last        = (k + 1 == count);
        bound_reports_q.push_back(r);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (bound_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: id=%0d up=%0d lo=%0d fired=%0d last=%0b",
                   got.subset_id, got.upper_bound, got.lower_bound,
                   got.fired_count, got.last);
        return;
      end
      want = bound_reports_q.pop_front();
      if (got.subset_id !== want.subset_id || got.upper_bound !== want.upper_bound ||
          got.lower_bound !== want.lower_bound ||
          got.fired_count !== want.fired_count || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp id=%0d up=%0d lo=%0d fired=%0d last=%0b",
                   want.subset_id, want.upper_bound, want.lower_bound,
                   want.fired_count, want.last);
          $display("          got id=%0d up=%0d lo=%0d fired=%0d last=%0b",
                   got.subset_id, got.upper_bound, got.lower_bound,
                   got.fired_count, got.last);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  item_t             item_i;
  logic              result_valid_o;
  result_t           result_o;
  logic              cfg_we_i;
  logic [PointW-1:0] cfg_wdata_i;

  bound_scoreboard board = new();
  int              items_sent;
  int              idle_cycles;
  bit              eager;

  always #5 clk_i = ~clk_i;

  subset_rank_bound_saturation_top u_top (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .item_i,
    .result_valid_o,
    .result_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic item_t load_item(logic [SubsetW-1:0] idx, logic [RankW-1:0] up,
                                      logic [RankW-1:0] lo);
    item_t it;
    it.operation    = OpLoad;
    it.subset_index = idx;
    it.rank_upper   = up;
    it.rank_lower   = lo;
    return it;
  endfunction

  function automatic item_t run_item();
    item_t it;
    it           = item_t'($urandom);
    it.operation = OpRun;
    return it;
  endfunction

  // Mostly consistent bounds inside the active subsets; the rest is noise.
  function automatic item_t random_load(int n);
    int unsigned idx;
    int unsigned pc;
    int unsigned lo;
    if ($urandom_range(0, 99) < 80) begin
      idx = $urandom_range(1, (1 << n) - 1);
      pc  = $countones(idx);
      lo  = $urandom_range(0, pc);
      return load_item(SubsetW'(idx), RankW'($urandom_range(lo, pc + 1)), RankW'(lo));
    end
    return load_item(SubsetW'($urandom_range(0, 31)), RankW'($urandom), RankW'($urandom));
  endfunction

  function automatic logic [PointW-1:0] pick_points();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 3'd0;
    if (r < 35) return 3'd1;
    if (r < 60) return 3'd2;
    if (r < 80) return 3'd3;
    if (r < 92) return 3'd4;
    if (r < 96) return 3'd5;
    if (r < 98) return 3'd6;
    return 3'd7;
  endfunction

  // Hold start until the item is taken, then maybe idle.
  task automatic send_item(input item_t it);
    int gap;
    gap = eager ? 0 : gap_len();
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    board.note_item(it);
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_points(input logic [PointW-1:0] value);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_points(value);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) board.check_result(result_o);
      if ((start && !busy) || result_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("** subset_rank_bound_saturation_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [PointW-1:0] pv;
    int                n_eff;
    int                loads;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    eager       = 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // power-on bounds at the reset point count
    send_item(run_item());

    // count of zero acts as one point; empty-set load is stored
    write_points(3'd0);
    send_item(load_item(5'd1, 8'd255, 8'd0));
    send_item(load_item(5'd0, 8'd0, 8'd255));
    send_item(run_item());

    // count above the maximum; extremes that drive the rule values negative
    write_points(3'd7);
    send_item(load_item(5'd31, 8'd255, 8'd255));
    send_item(load_item(5'd0, 8'd0, 8'd0));
    send_item(load_item(5'd16, 8'd0, 8'd255));
    send_item(load_item(5'd3, 8'd1, 8'd200));
    send_item(run_item());

    write_points(3'd3);
    send_item(load_item(5'd5, 8'hAA, 8'h55));
    send_item(load_item(5'd2, 8'h55, 8'hAA));
    send_item(load_item(5'd7, 8'd3, 8'd3));
    send_item(run_item());
    send_item(run_item());

    while (items_sent < ItemsTotal) begin
      pv = pick_points();
      write_points(pv);
      n_eff = (pv == 3'd0) ? 1 : (pv > PointW'(MaxPointsDef)) ? int'(MaxPointsDef) : int'(pv);
      eager = ($urandom_range(0, 3) == 0);
      loads = $urandom_range(0, 12);
      repeat (loads) send_item(random_load(n_eff));
      if ($urandom_range(0, 9) != 0) send_item(run_item());
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) send_item(random_load(n_eff));
        send_item(run_item());
      end
    end

    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("** subset_rank_bound_saturation_top: PASSED **");
    end else begin
      $display("** subset_rank_bound_saturation_top: FAILED **");
    end
    $finish;
  end

endmodule
